### hdl/apc_pkg.sv
// Shared types and constants for the Atbash/Playfair cipher block.
// No dependencies; imported by the digraph rule unit and the top level.
package apc_pkg;

    localparam int SQUARE_SIDE  = 5;
    localparam int SQUARE_CELLS = SQUARE_SIDE * SQUARE_SIDE;
    localparam int ALPHA_SIZE   = 26;

    // square position, 0 .. SQUARE_CELLS-1
    typedef logic [4:0] t_pos;
    // letter index, a = 0 .. z = 25
    typedef logic [4:0] t_letter;

    localparam t_letter LETTER_I = 5'd8;
    localparam t_letter LETTER_J = 5'd9;
    localparam t_letter LETTER_X = 5'd23;
    localparam t_letter LETTER_Z = 5'd25;

    localparam logic [1:0] OP_KEY    = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_TEXT   = 2'd2;
    localparam logic [1:0] OP_END    = 2'd3;

endpackage

### hdl/apc_digraph_rule.sv
// Playfair digraph rule unit: maps two square positions to their cipher positions.
// Depends on apc_pkg for the square size and position type.
module apc_digraph_rule (
    input  apc_pkg::t_pos i_pos_a,
    input  apc_pkg::t_pos i_pos_b,
    output apc_pkg::t_pos o_pos_a,
    output apc_pkg::t_pos o_pos_b
);
    import apc_pkg::*;

    function automatic logic [2:0] pos_row(input t_pos p);
        logic [2:0] r;
        r = 3'd0;
        for (int k = 1; k < SQUARE_SIDE; k++) begin
            if (p >= t_pos'(k * SQUARE_SIDE)) begin
                r = 3'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [2:0] step_wrap(input logic [2:0] v);
        return (v == 3'(SQUARE_SIDE - 1)) ? 3'd0 : v + 3'd1;
    endfunction

    logic [2:0] row_a, row_b, col_a, col_b;
    logic [2:0] nrow_a, nrow_b, ncol_a, ncol_b;

    always_comb begin
        row_a = pos_row(i_pos_a);
        row_b = pos_row(i_pos_b);
        col_a = 3'(i_pos_a - t_pos'(row_a * SQUARE_SIDE));
        col_b = 3'(i_pos_b - t_pos'(row_b * SQUARE_SIDE));
        nrow_a = row_a;
        nrow_b = row_b;
        ncol_a = col_a;
        ncol_b = col_b;
        if (row_a == row_b) begin
            ncol_a = step_wrap(col_a);
            ncol_b = step_wrap(col_b);
        end else if (col_a == col_b) begin
            nrow_a = step_wrap(row_a);
            nrow_b = step_wrap(row_b);
        end else begin
            ncol_a = col_b;
            ncol_b = col_a;
        end
    end

    assign o_pos_a = t_pos'(nrow_a * SQUARE_SIDE) + t_pos'(ncol_a);
    assign o_pos_b = t_pos'(nrow_b * SQUARE_SIDE) + t_pos'(ncol_b);

endmodule

### hdl/atbash_playfair_cipher.sv
// Atbash-mirrored Playfair cipher over a 5x5 square built from streamed key bytes.
// A key byte is placed when taken; finish square sweeps the alphabet one letter a cycle;
// a text byte that completes a pair reads both places, applies the digraph rule, reads both
// cipher letters and pushes first one then the other; the next request waits for the second
// push, so result stalls delay it. Reads go in turn: one read port on place memory and square.
// Reset (synchronous, active low) clears control, counts, hold and place valid bits.
module atbash_playfair_cipher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: atbash_enable
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    // request channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_char_byte,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_cipher_letter,
    output logic       o_last_of_pair
);
    import apc_pkg::*;

    // Sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FILL = 4'd1;  // sweep the alphabet into the square
    localparam logic [3:0] S_RDA  = 4'd2;  // read place of first letter
    localparam logic [3:0] S_RDB  = 4'd3;  // latch first place, read second
    localparam logic [3:0] S_CALC = 4'd4;  // apply the digraph rule
    localparam logic [3:0] S_SQA  = 4'd5;  // read first cipher letter
    localparam logic [3:0] S_SQB  = 4'd6;  // latch first, read second
    localparam logic [3:0] S_OUTA = 4'd7;  // push first letter when free
    localparam logic [3:0] S_OUTB = 4'd8;  // push second letter when free

    logic [3:0] r_state, n_state;

    // Playfair square and letter place store
    t_letter r_square   [SQUARE_CELLS];
    t_pos    r_place    [ALPHA_SIZE];
    logic    r_place_vld[ALPHA_SIZE];
    t_letter r_square_q;
    t_pos    r_place_q;

    logic       r_atbash;
    logic [4:0] r_count, n_count;   // placed letters, 0 .. SQUARE_CELLS
    logic [4:0] r_fill_k, n_fill_k; // alphabet sweep index
    t_letter    r_held, n_held;
    logic       r_held_vld, n_held_vld;
    t_letter    r_a, n_a, r_b, n_b;
    t_pos       r_pa;
    t_pos       r_ta, r_tb;
    t_letter    r_first;

    logic       r_out_vld;
    logic [6:0] r_out_letter;
    logic       r_out_last;

    // Decode of the incoming byte
    logic    byte_is_letter;
    t_letter byte_letter;
    t_letter key_letter;
    t_letter text_letter;

    always_comb begin
        byte_is_letter = 1'b0;
        byte_letter    = '0;
        if (i_char_byte >= 8'd97 && i_char_byte <= 8'd122) begin
            byte_is_letter = 1'b1;
            byte_letter    = 5'(i_char_byte - 8'd97);
        end else if (i_char_byte >= 8'd65 && i_char_byte <= 8'd90) begin
            byte_is_letter = 1'b1;
            byte_letter    = 5'(i_char_byte - 8'd65);
        end
        key_letter  = (byte_letter == LETTER_J) ? LETTER_I : byte_letter;
        text_letter = r_atbash ? (LETTER_Z - byte_letter) : byte_letter;
        if (text_letter == LETTER_J) begin
            text_letter = LETTER_I;
        end
    end

    logic accept;
    logic out_free;
    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_vld || !i_stall;

    // Rule unit: first position is registered, second comes from the place read
    t_pos pb;
    t_pos rule_ta, rule_tb;
    assign pb = r_place_vld[r_b] ? r_place_q : '0;

    apc_digraph_rule u_rule (
        .i_pos_a (r_pa),
        .i_pos_b (pb),
        .o_pos_a (rule_ta),
        .o_pos_b (rule_tb)
    );

    // Shared placement port used by key bytes and the fill sweep
    logic    place_we;
    t_letter place_letter;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_fill_k   = r_fill_k;
        n_held     = r_held;
        n_held_vld = r_held_vld;
        n_a        = r_a;
        n_b        = r_b;
        place_we     = 1'b0;
        place_letter = key_letter;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_opcode)
                        OP_KEY: begin
                            // drop non-letters, repeats and anything past a full square
                            if (byte_is_letter && r_count < 5'(SQUARE_CELLS)
                                    && !r_place_vld[key_letter]) begin
                                place_we = 1'b1;
                                n_count  = r_count + 5'd1;
                            end
                        end
                        OP_FINISH: begin
                            n_fill_k = '0;
                            n_state  = S_FILL;
                        end
                        OP_TEXT: begin
                            if (byte_is_letter) begin
                                if (!r_held_vld) begin
                                    n_held     = text_letter;
                                    n_held_vld = 1'b1;
                                end else begin
                                    n_a = r_held;
                                    n_state = S_RDA;
                                    if (r_held == text_letter) begin
                                        // doubled letter: pair with x, keep the hold
                                        n_b = LETTER_X;
                                    end else begin
                                        n_b        = text_letter;
                                        n_held_vld = 1'b0;
                                    end
                                end
                            end
                        end
                        OP_END: begin
                            if (r_held_vld) begin
                                n_a        = r_held;
                                n_b        = LETTER_X;
                                n_held_vld = 1'b0;
                                n_state    = S_RDA;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FILL: begin
                place_letter = r_fill_k;
                if (r_fill_k != LETTER_J && r_count < 5'(SQUARE_CELLS)
                        && !r_place_vld[r_fill_k]) begin
                    place_we = 1'b1;
                    n_count  = r_count + 5'd1;
                end
                n_fill_k = r_fill_k + 5'd1;
                if (r_fill_k == 5'(ALPHA_SIZE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_RDA:  n_state = S_RDB;
            S_RDB:  n_state = S_CALC;
            S_CALC: n_state = S_SQA;
            S_SQA:  n_state = S_SQB;
            S_SQB:  n_state = S_OUTA;
            S_OUTA: begin
                if (out_free) begin
                    n_state = S_OUTB;
                end
            end
            S_OUTB: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_fill_k   <= '0;
            r_held     <= '0;
            r_held_vld <= 1'b0;
            r_atbash   <= 1'b1;
            for (int k = 0; k < ALPHA_SIZE; k++) begin
                r_place_vld[k] <= 1'b0;
            end
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_fill_k   <= n_fill_k;
            r_held     <= n_held;
            r_held_vld <= n_held_vld;
            if (i_cfg_we) begin
                r_atbash <= i_cfg_data;
            end
            if (place_we) begin
                r_place_vld[place_letter] <= 1'b1;
            end
        end
    end

    // Square and place memories: one write, one registered read each
    always_ff @(posedge i_clk) begin
        if (place_we) begin
            r_square[r_count]     <= place_letter;
            r_place[place_letter] <= r_count;
        end
        if (r_state == S_RDA) begin
            r_place_q <= r_place[r_a];
        end else if (r_state == S_RDB) begin
            r_place_q <= r_place[r_b];
        end
        if (r_state == S_SQA) begin
            r_square_q <= r_square[r_ta];
        end else if (r_state == S_SQB) begin
            r_square_q <= r_square[r_tb];
        end
    end

    // Pair datapath
    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        if (r_state == S_RDB) begin
            // a letter with no place counts as position 0
            r_pa <= r_place_vld[r_a] ? r_place_q : '0;
        end
        if (r_state == S_CALC) begin
            r_ta <= rule_ta;
            r_tb <= rule_tb;
        end
        if (r_state == S_SQB) begin
            r_first <= r_square_q;
        end
    end

    // Output register: load a letter whenever the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= (r_state == S_OUTA) || (r_state == S_OUTB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_state == S_OUTA) begin
            r_out_letter <= 7'd65 + 7'(r_first);
            r_out_last   <= 1'b0;
        end else if (out_free && r_state == S_OUTB) begin
            r_out_letter <= 7'd65 + 7'(r_square_q);
            r_out_last   <= 1'b1;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_cipher_letter = r_out_letter;
    assign o_last_of_pair  = r_out_last;

endmodule
